// File: sv/sn2f_pkg.sv
// ----------------------------------------------------------------------------
// sn2f_pkg
// shared types, constants and permutation table for the 2d fractal noise block
// ----------------------------------------------------------------------------
package sn2f_pkg;

    localparam int MAX_OCTAVES_DEF     = 8;
    localparam int COORD_FRAC_BITS_DEF = 16;

    // register indexes of the configuration port
    localparam logic [1:0] REG_BASE_FREQ = 2'd0;
    localparam logic [1:0] REG_BASE_AMP  = 2'd1;
    localparam logic [1:0] REG_LACUNAR   = 2'd2;
    localparam logic [1:0] REG_PERSIST   = 2'd3;

    localparam logic [31:0] BASE_FREQ_RST = 32'd65536;
    localparam logic [15:0] BASE_AMP_RST  = 16'd256;
    localparam logic [15:0] LACUNAR_RST   = 16'd512;
    localparam logic [15:0] PERSIST_RST   = 16'd32768;

    // fixed point constants
    localparam logic signed [31:0] SKEW_Q32   = 32'sd1572067135;
    localparam logic signed [30:0] UNSKEW_Q32 = 31'sd907633384;
    localparam logic signed [31:0] UNSKEW_Q24 = 32'sd3545443;
    localparam logic signed [31:0] ONE_Q24    = 32'sd16777216;
    localparam logic signed [41:0] HALF_Q24   = 42'sd8388608;
    localparam logic signed [23:0] SCALE_Q16  = 24'sd2964234;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SCALE,
        OP_SKEW,
        OP_CELL,
        OP_UNSKEW,
        OP_OFFS,
        OP_HASH1,
        OP_HASH2,
        OP_SQ,
        OP_T2,
        OP_T4,
        OP_GRAD,
        OP_NOISE,
        OP_ACCUM,
        OP_DIVINIT
    } dp_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SCALE,
        ST_SKEW,
        ST_CELL,
        ST_UNSKEW,
        ST_OFFS,
        ST_HASH1,
        ST_HASH2,
        ST_SQ,
        ST_T2,
        ST_T4,
        ST_GRAD,
        ST_NOISE,
        ST_ACCUM,
        ST_DIVINIT,
        ST_DIV,
        ST_FIN
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] corner;
        logic       div_step;
        logic       finish;
    } dp_cmd_t;

    typedef struct packed {
        logic last_octave;
    } dp_stat_t;

    localparam logic [7:0] PERM_ROM [256] = '{
        8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
        8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
        8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
        8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
        8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
        8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
        8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
        8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
        8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
        8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
        8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
        8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
        8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
        8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
        8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
        8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
        8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
        8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
        8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
        8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
        8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
        8'd215,8'd61,8'd156,8'd180
    };

endpackage

// File: sv/sn2f_ctrl.sv
// ----------------------------------------------------------------------------
// sn2f_ctrl
// sequencer for the octave loop, the corner loop and the serial divider
// ----------------------------------------------------------------------------
module sn2f_ctrl #(
    parameter int DIV_STEPS = 57
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    output sn2f_pkg::dp_cmd_t  cmd,
    input  sn2f_pkg::dp_stat_t stat
);

    localparam int CNT_W = $clog2(DIV_STEPS);

    sn2f_pkg::ctrl_state_t state_reg, state_next;
    logic [1:0]       corner_reg, corner_next;
    logic [CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic             done_reg, done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sn2f_pkg::ST_IDLE;
            corner_reg  <= '0;
            div_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            corner_reg  <= corner_next;
            div_cnt_reg <= div_cnt_next;
            done_reg    <= done_next;
        end
    end

    // next state
    always_comb
    begin
        state_next   = state_reg;
        corner_next  = corner_reg;
        div_cnt_next = div_cnt_reg;
        done_next    = 1'b0;
        case (state_reg)
            sn2f_pkg::ST_IDLE:    if (start) state_next = sn2f_pkg::ST_SCALE;
            sn2f_pkg::ST_SCALE:   state_next = sn2f_pkg::ST_SKEW;
            sn2f_pkg::ST_SKEW:    state_next = sn2f_pkg::ST_CELL;
            sn2f_pkg::ST_CELL:    state_next = sn2f_pkg::ST_UNSKEW;
            sn2f_pkg::ST_UNSKEW:  state_next = sn2f_pkg::ST_OFFS;
            sn2f_pkg::ST_OFFS:    state_next = sn2f_pkg::ST_HASH1;
            sn2f_pkg::ST_HASH1:   state_next = sn2f_pkg::ST_HASH2;
            sn2f_pkg::ST_HASH2:
            begin
                state_next  = sn2f_pkg::ST_SQ;
                corner_next = '0;
            end
            sn2f_pkg::ST_SQ:      state_next = sn2f_pkg::ST_T2;
            sn2f_pkg::ST_T2:      state_next = sn2f_pkg::ST_T4;
            sn2f_pkg::ST_T4:      state_next = sn2f_pkg::ST_GRAD;
            sn2f_pkg::ST_GRAD:
            begin
                if (corner_reg == 2'd2)
                    state_next = sn2f_pkg::ST_NOISE;
                else
                begin
                    state_next  = sn2f_pkg::ST_SQ;
                    corner_next = corner_reg + 2'd1;
                end
            end
            sn2f_pkg::ST_NOISE:   state_next = sn2f_pkg::ST_ACCUM;
            sn2f_pkg::ST_ACCUM:
                state_next = stat.last_octave ? sn2f_pkg::ST_DIVINIT : sn2f_pkg::ST_SCALE;
            sn2f_pkg::ST_DIVINIT:
            begin
                state_next   = sn2f_pkg::ST_DIV;
                div_cnt_next = '0;
            end
            sn2f_pkg::ST_DIV:
            begin
                if (div_cnt_reg == CNT_W'(DIV_STEPS - 1))
                    state_next = sn2f_pkg::ST_FIN;
                else
                    div_cnt_next = div_cnt_reg + CNT_W'(1);
            end
            sn2f_pkg::ST_FIN:
            begin
                state_next = sn2f_pkg::ST_IDLE;
                done_next  = 1'b1;
            end
            default:              state_next = sn2f_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd.op       = sn2f_pkg::OP_NONE;
        cmd.corner   = corner_reg;
        cmd.div_step = 1'b0;
        cmd.finish   = 1'b0;
        case (state_reg)
            sn2f_pkg::ST_IDLE:    cmd.op = start ? sn2f_pkg::OP_LOAD : sn2f_pkg::OP_NONE;
            sn2f_pkg::ST_SCALE:   cmd.op = sn2f_pkg::OP_SCALE;
            sn2f_pkg::ST_SKEW:    cmd.op = sn2f_pkg::OP_SKEW;
            sn2f_pkg::ST_CELL:    cmd.op = sn2f_pkg::OP_CELL;
            sn2f_pkg::ST_UNSKEW:  cmd.op = sn2f_pkg::OP_UNSKEW;
            sn2f_pkg::ST_OFFS:    cmd.op = sn2f_pkg::OP_OFFS;
            sn2f_pkg::ST_HASH1:   cmd.op = sn2f_pkg::OP_HASH1;
            sn2f_pkg::ST_HASH2:   cmd.op = sn2f_pkg::OP_HASH2;
            sn2f_pkg::ST_SQ:      cmd.op = sn2f_pkg::OP_SQ;
            sn2f_pkg::ST_T2:      cmd.op = sn2f_pkg::OP_T2;
            sn2f_pkg::ST_T4:      cmd.op = sn2f_pkg::OP_T4;
            sn2f_pkg::ST_GRAD:    cmd.op = sn2f_pkg::OP_GRAD;
            sn2f_pkg::ST_NOISE:   cmd.op = sn2f_pkg::OP_NOISE;
            sn2f_pkg::ST_ACCUM:   cmd.op = sn2f_pkg::OP_ACCUM;
            sn2f_pkg::ST_DIVINIT: cmd.op = sn2f_pkg::OP_DIVINIT;
            sn2f_pkg::ST_DIV:     cmd.div_step = 1'b1;
            sn2f_pkg::ST_FIN:     cmd.finish = 1'b1;
            default:              cmd.op = sn2f_pkg::OP_NONE;
        endcase
    end

    assign busy = (state_reg != sn2f_pkg::ST_IDLE);
    assign done = done_reg;

endmodule

// File: sv/sn2f_dpath.sv
// ----------------------------------------------------------------------------
// sn2f_dpath
// configuration registers, simplex noise arithmetic, octave sums and divider
// ----------------------------------------------------------------------------
module sn2f_dpath #(
    parameter int MAX_OCTAVES     = sn2f_pkg::MAX_OCTAVES_DEF,
    parameter int COORD_FRAC_BITS = sn2f_pkg::COORD_FRAC_BITS_DEF,
    parameter int NUM_W           = 54,
    parameter int DEN_W           = 20
) (
    input  logic               clk,
    input  logic               rst_n,
    input  sn2f_pkg::dp_cmd_t  cmd,
    output sn2f_pkg::dp_stat_t stat,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic [3:0]         octave_count,
    output logic signed [15:0] noise_value
);

    localparam int F     = COORD_FRAC_BITS;
    localparam int OCT_W = $clog2(MAX_OCTAVES + 1);
    localparam int REM_W = DEN_W + 1;

    // configuration
    logic [31:0] base_freq_reg;
    logic [15:0] base_amp_reg, lacunar_reg, persist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_freq_reg <= sn2f_pkg::BASE_FREQ_RST;
            base_amp_reg  <= sn2f_pkg::BASE_AMP_RST;
            lacunar_reg   <= sn2f_pkg::LACUNAR_RST;
            persist_reg   <= sn2f_pkg::PERSIST_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                sn2f_pkg::REG_BASE_FREQ: base_freq_reg <= cfg_data;
                sn2f_pkg::REG_BASE_AMP:  base_amp_reg  <= cfg_data[15:0];
                sn2f_pkg::REG_LACUNAR:   lacunar_reg   <= cfg_data[15:0];
                sn2f_pkg::REG_PERSIST:   persist_reg   <= cfg_data[15:0];
                default:                 base_freq_reg <= base_freq_reg;
            endcase
        end
    end

    // octave bookkeeping
    logic [OCT_W-1:0] oct_total_reg, oct_idx_reg;
    logic [3:0]       oct_in;
    logic [4:0]       oct_cl;

    always_comb
    begin
        oct_in = (octave_count == 4'd0) ? 4'd1 : octave_count;
        oct_cl = ({1'b0, oct_in} > 5'(MAX_OCTAVES)) ? 5'(MAX_OCTAVES) : {1'b0, oct_in};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oct_total_reg <= '0;
            oct_idx_reg   <= '0;
        end
        else if (cmd.op == sn2f_pkg::OP_LOAD)
        begin
            oct_total_reg <= OCT_W'(oct_cl);
            oct_idx_reg   <= '0;
        end
        else if (cmd.op == sn2f_pkg::OP_ACCUM)
            oct_idx_reg <= oct_idx_reg + OCT_W'(1);
    end

    assign stat.last_octave = ((oct_idx_reg + OCT_W'(1)) == oct_total_reg);

    // payload registers
    logic signed [31:0]    cx_reg, cy_reg, px_reg, py_reg;
    logic [31:0]           freq_reg;
    logic [15:0]           amp_reg;
    logic signed [32:0]    s_reg;
    logic signed [33:0]    i_reg, j_reg;
    logic signed [34:0]    ij_reg;
    logic signed [39:0]    t_reg;
    logic signed [31:0]    x0_reg, y0_reg, x1_reg, y1_reg, x2_reg, y2_reg;
    logic                  i1_reg;
    logic [7:0]            ra_reg, rb_reg, rc_reg, h0_reg, h1_reg, h2_reg;
    logic [23:0]           tq_reg;
    logic signed [35:0]    sum_reg;
    logic signed [32:0]    n_reg;
    logic signed [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0]      den_reg;
    logic [NUM_W-1:0]      dvd_reg;
    logic [REM_W-1:0]      rem_reg, dvs_reg;
    logic                  neg_reg;
    logic signed [15:0]    noise_reg;

    // combinational terms
    logic signed [64:0]    mx, my, mxs, mys;
    logic signed [32:0]    sxy;
    logic signed [64:0]    mskew;
    logic signed [33:0]    xs, ys;
    logic signed [65:0]    munsk;
    logic signed [63:0]    ex, ey;
    logic                  i1;
    logic [7:0]            i8, j8;
    logic signed [31:0]    dx, dy;
    logic [7:0]            hh;
    logic signed [63:0]    sqx, sqy;
    logic signed [41:0]    tq;
    logic [47:0]           tt;
    logic signed [31:0]    gu, gv;
    logic signed [33:0]    ug, vg;
    logic signed [34:0]    g;
    logic signed [59:0]    mg;
    logic signed [59:0]    mn;
    logic signed [49:0]    an;
    logic [47:0]           fl;
    logic [31:0]           ap;
    logic [REM_W:0]        rsh;
    logic                  ge;

    function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
        logic signed [64:0] hi, lo;
        hi = 65'sd2147483647;
        lo = -65'sd2147483648;
        if (v > hi)
            sat32 = 32'sh7FFFFFFF;
        else if (v < lo)
            sat32 = 32'sh80000000;
        else
            sat32 = v[31:0];
    endfunction

    always_comb
    begin
        mx    = $signed(cx_reg) * $signed({1'b0, freq_reg});
        my    = $signed(cy_reg) * $signed({1'b0, freq_reg});
        mxs   = mx >>> 16;
        mys   = my >>> 16;
        sxy   = 33'(px_reg) + 33'(py_reg);
        mskew = 65'(sxy) * 65'(sn2f_pkg::SKEW_Q32);
        xs    = 34'(px_reg) + 34'(s_reg);
        ys    = 34'(py_reg) + 34'(s_reg);
        munsk = 66'(ij_reg) * 66'(sn2f_pkg::UNSKEW_Q32);
        ex    = 64'(px_reg) - (64'(i_reg) <<< F) + 64'(t_reg);
        ey    = 64'(py_reg) - (64'(j_reg) <<< F) + 64'(t_reg);
        i1    = (x0_reg > y0_reg);
        i8    = i_reg[7:0];
        j8    = j_reg[7:0];
        case (cmd.corner)
            2'd0:    begin dx = x0_reg; dy = y0_reg; hh = h0_reg; end
            2'd1:    begin dx = x1_reg; dy = y1_reg; hh = h1_reg; end
            default: begin dx = x2_reg; dy = y2_reg; hh = h2_reg; end
        endcase
        sqx   = 64'(dx) * 64'(dx);
        sqy   = 64'(dy) * 64'(dy);
        tq    = sn2f_pkg::HALF_Q24 - 42'(sqx >>> 24) - 42'(sqy >>> 24);
        tt    = 48'(tq_reg) * 48'(tq_reg);
        // gradient: code bit 2 swaps axes, bits 0 and 1 flip signs
        gu    = hh[2] ? dy : dx;
        gv    = hh[2] ? dx : dy;
        ug    = hh[0] ? -34'(gu) : 34'(gu);
        vg    = hh[1] ? -(34'(gv) <<< 1) : (34'(gv) <<< 1);
        g     = 35'(ug) + 35'(vg);
        mg    = 60'($signed({1'b0, tq_reg})) * 60'(g);
        mn    = 60'(sum_reg) * 60'(sn2f_pkg::SCALE_Q16);
        an    = 50'($signed({1'b0, amp_reg})) * 50'(n_reg);
        fl    = 48'(freq_reg) * 48'(lacunar_reg);
        ap    = 32'(amp_reg) * 32'(persist_reg);
        rsh   = {rem_reg, dvd_reg[NUM_W-1]};
        ge    = (rsh >= {1'b0, dvs_reg});
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            sn2f_pkg::OP_LOAD:
            begin
                cx_reg   <= coord_x;
                cy_reg   <= coord_y;
                freq_reg <= base_freq_reg;
                amp_reg  <= base_amp_reg;
                num_reg  <= '0;
                den_reg  <= '0;
            end
            sn2f_pkg::OP_SCALE:
            begin
                px_reg <= sat32(mxs);
                py_reg <= sat32(mys);
            end
            sn2f_pkg::OP_SKEW:   s_reg <= 33'(mskew >>> 32);
            sn2f_pkg::OP_CELL:
            begin
                i_reg  <= xs >>> F;
                j_reg  <= ys >>> F;
                ij_reg <= 35'(xs >>> F) + 35'(ys >>> F);
            end
            sn2f_pkg::OP_UNSKEW: t_reg <= 40'(munsk >>> (32 - F));
            sn2f_pkg::OP_OFFS:
            begin
                x0_reg <= 32'(ex <<< (24 - F));
                y0_reg <= 32'(ey <<< (24 - F));
            end
            sn2f_pkg::OP_HASH1:
            begin
                i1_reg <= i1;
                x1_reg <= x0_reg - (i1 ? sn2f_pkg::ONE_Q24 : 32'sd0) + sn2f_pkg::UNSKEW_Q24;
                y1_reg <= y0_reg - (i1 ? 32'sd0 : sn2f_pkg::ONE_Q24) + sn2f_pkg::UNSKEW_Q24;
                x2_reg <= x0_reg - sn2f_pkg::ONE_Q24 + (sn2f_pkg::UNSKEW_Q24 <<< 1);
                y2_reg <= y0_reg - sn2f_pkg::ONE_Q24 + (sn2f_pkg::UNSKEW_Q24 <<< 1);
                ra_reg <= sn2f_pkg::PERM_ROM[j8];
                rb_reg <= sn2f_pkg::PERM_ROM[j8 + {7'd0, !i1}];
                rc_reg <= sn2f_pkg::PERM_ROM[j8 + 8'd1];
            end
            sn2f_pkg::OP_HASH2:
            begin
                h0_reg  <= sn2f_pkg::PERM_ROM[i8 + ra_reg];
                h1_reg  <= sn2f_pkg::PERM_ROM[i8 + {7'd0, i1_reg} + rb_reg];
                h2_reg  <= sn2f_pkg::PERM_ROM[i8 + 8'd1 + rc_reg];
                sum_reg <= '0;
            end
            // falloff clamps at zero, which zeroes the corner term
            sn2f_pkg::OP_SQ:     tq_reg <= (tq < 0) ? 24'd0 : tq[23:0];
            sn2f_pkg::OP_T2:     tq_reg <= tt[47:24];
            sn2f_pkg::OP_T4:     tq_reg <= tt[47:24];
            sn2f_pkg::OP_GRAD:   sum_reg <= sum_reg + 36'(mg >>> 24);
            sn2f_pkg::OP_NOISE:  n_reg <= 33'(mn >>> 24);
            sn2f_pkg::OP_ACCUM:
            begin
                num_reg  <= num_reg + NUM_W'(an);
                den_reg  <= den_reg + DEN_W'(amp_reg);
                freq_reg <= (|fl[47:40]) ? 32'hFFFFFFFF : fl[39:8];
                amp_reg  <= ap[31:16];
            end
            sn2f_pkg::OP_DIVINIT:
            begin
                neg_reg <= num_reg[NUM_W-1];
                dvd_reg <= num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
                rem_reg <= '0;
                dvs_reg <= {den_reg, 1'b0};
            end
            default:
            begin
                if (cmd.div_step)
                begin
                    rem_reg <= ge ? REM_W'(rsh - {1'b0, dvs_reg}) : REM_W'(rsh);
                    dvd_reg <= {dvd_reg[NUM_W-2:0], ge};
                end
                if (cmd.finish)
                begin
                    if (den_reg == '0)
                        noise_reg <= 16'sd0;
                    else if (!neg_reg)
                        noise_reg <= (dvd_reg > NUM_W'(32767)) ? 16'sh7FFF
                                                               : $signed(dvd_reg[15:0]);
                    else
                        noise_reg <= (dvd_reg > NUM_W'(32768)) ? 16'sh8000
                                                               : $signed(-dvd_reg[15:0]);
                end
            end
        endcase
    end

    assign noise_value = noise_reg;

endmodule

// File: sv/simplex_noise_2d_fractal.sv
// ----------------------------------------------------------------------------
// simplex_noise_2d_fractal
// fractal sum of 2d simplex noise octaves, normalized to q1.15
// ----------------------------------------------------------------------------
//  channel  | ports                                     | handshake
//  ---------+-------------------------------------------+--------------------------
//  input    | coord_x, coord_y, octave_count            | start & !busy
//  result   | noise_value                               | done, one cycle, no stall
//  config   | cfg_write, cfg_index, cfg_data            | cfg_write, no wait
//
//  one item runs, per octave, 5 setup steps, 2 hash lookups, 4 steps for
//  each of the 3 corners, noise scale and accumulate, then the divider
//  init, the bit-serial normalizing divider steps and the finish step;
//  done is registered after that; a new item is taken in that done cycle
//  reset clears control state and loads the register defaults
//  the receiver cannot stall: done is a single-cycle strobe
// ----------------------------------------------------------------------------
module simplex_noise_2d_fractal #(
    parameter int MAX_OCTAVES     = sn2f_pkg::MAX_OCTAVES_DEF,
    parameter int COORD_FRAC_BITS = sn2f_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic [3:0]         octave_count,
    output logic               done,
    output logic signed [15:0] noise_value,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    // amplitude sum width and weighted sum width grow with the octave count
    localparam int DEN_W = 16 + $clog2(MAX_OCTAVES + 1);
    localparam int NUM_W = 50 + $clog2(MAX_OCTAVES + 1);

    sn2f_pkg::dp_cmd_t  cmd;
    sn2f_pkg::dp_stat_t stat;

    // sequencer: octave loop, corner loop, divider steps
    sn2f_ctrl #(
        .DIV_STEPS (NUM_W)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .stat  (stat)
    );

    // arithmetic, lattice hashing and configuration registers
    sn2f_dpath #(
        .MAX_OCTAVES     (MAX_OCTAVES),
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .NUM_W           (NUM_W),
        .DEN_W           (DEN_W)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .octave_count (octave_count),
        .noise_value  (noise_value)
    );

endmodule

// File: verif/sn2f_checker.sv
// ----------------------------------------------------------------------------
// sn2f_checker
// predicts the fractal noise value for every accepted item and compares it
// with each done strobe of the block, in order
// ----------------------------------------------------------------------------
module sn2f_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic [3:0]         octave_count,
    input  logic               done,
    input  logic signed [15:0] noise_value,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint FRAC = sn2f_pkg::COORD_FRAC_BITS_DEF;

    logic [31:0] freq_reg;
    logic [15:0] amp_reg;
    logic [15:0] lac_reg;
    logic [15:0] pers_reg;

    logic signed [15:0] noise_q[$];

    function automatic longint perm_at(longint idx);
        return longint'(sn2f_pkg::PERM_ROM[idx & 255]);
    endfunction

    function automatic longint corner_term(longint dx, longint dy, longint h);
        longint t;
        longint u;
        longint v;
        longint g;
        longint code;
        code = h & 7;
        t = longint'(sn2f_pkg::HALF_Q24) - ((dx * dx) >>> 24) - ((dy * dy) >>> 24);
        if (t < 0)
            return 0;
        t = (t * t) >>> 24;
        t = (t * t) >>> 24;
        u = (code < 4) ? dx : dy;
        v = (code < 4) ? dy : dx;
        g = ((code & 1) ? -u : u) + ((code & 2) ? -2 * v : 2 * v);
        return (t * g) >>> 24;
    endfunction

    // one octave of simplex noise, result in q.16
    function automatic longint simplex_at(longint x, longint y);
        longint s, i, j, t, x0, y0, i1, j1, x1, y1, x2, y2, h0, h1, h2, total;
        s  = ((x + y) * longint'(sn2f_pkg::SKEW_Q32)) >>> 32;
        i  = (x + s) >>> FRAC;
        j  = (y + s) >>> FRAC;
        t  = ((i + j) * longint'(sn2f_pkg::UNSKEW_Q32)) >>> (32 - FRAC);
        x0 = (x - (i << FRAC) + t) * (longint'(1) << (24 - FRAC));
        y0 = (y - (j << FRAC) + t) * (longint'(1) << (24 - FRAC));
        i1 = (x0 > y0) ? 1 : 0;
        j1 = 1 - i1;
        x1 = x0 - i1 * longint'(sn2f_pkg::ONE_Q24) + longint'(sn2f_pkg::UNSKEW_Q24);
        y1 = y0 - j1 * longint'(sn2f_pkg::ONE_Q24) + longint'(sn2f_pkg::UNSKEW_Q24);
        x2 = x0 - longint'(sn2f_pkg::ONE_Q24) + 2 * longint'(sn2f_pkg::UNSKEW_Q24);
        y2 = y0 - longint'(sn2f_pkg::ONE_Q24) + 2 * longint'(sn2f_pkg::UNSKEW_Q24);
        h0 = perm_at(i + perm_at(j));
        h1 = perm_at(i + i1 + perm_at(j + j1));
        h2 = perm_at(i + 1 + perm_at(j + 1));
        total = corner_term(x0, y0, h0) + corner_term(x1, y1, h1)
              + corner_term(x2, y2, h2);
        return (total * longint'(sn2f_pkg::SCALE_Q16)) >>> 24;
    endfunction

    function automatic longint scaled_coord(longint c, longint f);
        longint p;
        p = (c * f) >>> 16;
        if (p > 64'sd2147483647)
            p = 64'sd2147483647;
        if (p < -64'sd2147483648)
            p = -64'sd2147483648;
        return p;
    endfunction

    function automatic logic signed [15:0] fractal_noise(longint cx, longint cy,
                                                         int oct);
        longint f, a, num, den, q, n;
        f = longint'(freq_reg);
        a = longint'(amp_reg);
        num = 0;
        den = 0;
        q = 0;
        if (oct == 0)
            oct = 1;
        if (oct > sn2f_pkg::MAX_OCTAVES_DEF)
            oct = sn2f_pkg::MAX_OCTAVES_DEF;
        for (int k = 0; k < oct; k++)
        begin
            n = simplex_at(scaled_coord(cx, f), scaled_coord(cy, f));
            num += a * n;
            den += a;
            f = (f * longint'(lac_reg)) >>> 8;
            if (f > 64'sd4294967295)
                f = 64'sd4294967295;
            a = (a * longint'(pers_reg)) >>> 16;
        end
        if (den > 0)
        begin
            q = num / (2 * den);
            if (q > 32767)
                q = 32767;
            if (q < -32768)
                q = -32768;
        end
        return q[15:0];
    endfunction

    assign pending = noise_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg = sn2f_pkg::BASE_FREQ_RST;
            amp_reg  = sn2f_pkg::BASE_AMP_RST;
            lac_reg  = sn2f_pkg::LACUNAR_RST;
            pers_reg = sn2f_pkg::PERSIST_RST;
            noise_q.delete();
        end
        else
        begin
            if (done)
            begin
                if (noise_q.size() == 0)
                begin
                    $error("noise_value: result with no item pending, actual %0d",
                           noise_value);
                    fail_count++;
                end
                else
                begin
                    logic signed [15:0] want;
                    want = noise_q.pop_front();
                    if (noise_value !== want)
                    begin
                        $error("noise_value: expected %0d, actual %0d",
                               want, noise_value);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                noise_q.push_back(fractal_noise(longint'(coord_x), longint'(coord_y),
                                                int'(octave_count)));
            if (cfg_write)
            begin
                case (cfg_index)
                    sn2f_pkg::REG_BASE_FREQ: freq_reg = cfg_data;
                    sn2f_pkg::REG_BASE_AMP:  amp_reg  = cfg_data[15:0];
                    sn2f_pkg::REG_LACUNAR:   lac_reg  = cfg_data[15:0];
                    sn2f_pkg::REG_PERSIST:   pers_reg = cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    initial fail_count = 0;

endmodule

// File: verif/tb_simplex_noise_2d_fractal.sv
// ----------------------------------------------------------------------------
// tb_simplex_noise_2d_fractal
// drives points and octave counts into the fractal noise block under several
// register settings; a side checker predicts and compares every result
// ----------------------------------------------------------------------------
module tb_simplex_noise_2d_fractal;
    timeunit 1ns;
    timeprecision 1ps;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic [3:0]         octave_count;
    logic               done;
    logic signed [15:0] noise_value;
    logic               cfg_write;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;
    int                 fail_count;
    int                 pending;

    simplex_noise_2d_fractal i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .octave_count (octave_count),
        .done         (done),
        .noise_value  (noise_value),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    sn2f_checker i_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .octave_count (octave_count),
        .done         (done),
        .noise_value  (noise_value),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // called at a falling edge; returns at the falling edge after acceptance
    // with start still high, so a burst can go straight on
    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [3:0] oct);
        start        = 1'b1;
        coord_x      = x;
        coord_y      = y;
        octave_count = oct;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    // write happens only with the block idle
    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    // stop sending and wait for every outstanding item to come back
    task automatic drain();
        start = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // mix of points near the origin, full-range points and edge values
    function automatic logic [31:0] rand_coord();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
        else if (pick < 8)
            return $urandom;
        else
            case ($urandom_range(0, 3))
                0: return 32'h7fff_ffff;
                1: return 32'h8000_0000;
                2: return 32'h0000_0000;
                default: return 32'hffff_ffff;
            endcase
    endfunction

    // short octave counts dominate so the run stays short
    function automatic logic [3:0] rand_octaves();
        if ($urandom_range(0, 9) < 7)
            return 4'($urandom_range(0, 4));
        return 4'($urandom_range(0, 15));
    endfunction

    // random burst traffic, with one full drain in the middle and one at the end
    task automatic random_points(int count);
        int burst;
        burst = $urandom_range(1, 12);
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 2)
                drain();
            send_point(rand_coord(), rand_coord(), rand_octaves());
            burst--;
            if (burst == 0)
            begin
                start = 1'b0;
                coord_x = $urandom;
                coord_y = $urandom;
                repeat ($urandom_range(1, 40)) @(negedge clk);
                burst = $urandom_range(1, 12);
            end
        end
        drain();
    endtask

    // register settings per phase: frequency, amplitude, lacunarity, persistence
    logic [31:0] set_freq [6] = '{32'h0001_0000, 32'h0000_0000, 32'hffff_ffff,
                                  32'h0000_4000, 32'h0040_0000, 32'h0000_0001};
    logic [31:0] set_amp  [6] = '{32'h0000_0100, 32'h0000_0001, 32'hffff_ffff,
                                  32'h0000_0100, 32'h0001_8000, 32'h0000_0040};
    logic [31:0] set_lac  [6] = '{32'h0000_0200, 32'h0000_ffff, 32'h0000_0000,
                                  32'h0000_0180, 32'h0000_ffff, 32'hdead_0300};
    logic [31:0] set_pers [6] = '{32'h0000_8000, 32'h0000_0000, 32'h0000_ffff,
                                  32'h0000_c000, 32'h0000_0001, 32'hbeef_4000};

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        coord_x      = '0;
        coord_y      = '0;
        octave_count = '0;
        cfg_write    = 1'b0;
        cfg_index    = sn2f_pkg::REG_BASE_FREQ;
        cfg_data     = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: every octave count including zero and above the maximum
        for (int k = 0; k < 16; k++)
            send_point(32'h0001_8000 + k * 32'h0000_3a71, 32'h0000_c000 - k * 32'h1234,
                       k[3:0]);
        // directed: coordinate extremes and saturation when scaled
        send_point(32'h0000_0000, 32'h0000_0000, 4'd1);
        send_point(32'h7fff_ffff, 32'h7fff_ffff, 4'd8);
        send_point(32'h8000_0000, 32'h8000_0000, 4'd8);
        send_point(32'h7fff_ffff, 32'h8000_0000, 4'd3);
        send_point(32'h8000_0000, 32'h7fff_ffff, 4'd3);
        send_point(32'hffff_ffff, 32'h0000_0001, 4'd2);
        send_point(32'hfff0_8000, 32'h000f_7fff, 4'd1);
        send_point(32'h5555_5555, 32'haaaa_aaaa, 4'd15);
        drain();

        // each phase loads all four registers, then random traffic
        for (int p = 0; p < 6; p++)
        begin
            write_reg(sn2f_pkg::REG_BASE_FREQ, set_freq[p]);
            write_reg(sn2f_pkg::REG_BASE_AMP,  set_amp[p]);
            write_reg(sn2f_pkg::REG_LACUNAR,   set_lac[p]);
            write_reg(sn2f_pkg::REG_PERSIST,   set_pers[p]);
            random_points(160);
        end
        // random settings, amplitude kept nonzero
        for (int p = 0; p < 3; p++)
        begin
            write_reg(sn2f_pkg::REG_BASE_FREQ, $urandom_range(0, 32'h0004_0000));
            write_reg(sn2f_pkg::REG_BASE_AMP,
                      {16'h0000, 16'($urandom_range(1, 32'hffff))});
            write_reg(sn2f_pkg::REG_LACUNAR,   $urandom);
            write_reg(sn2f_pkg::REG_PERSIST,   $urandom);
            random_points(100);
        end

        drain();
        repeat (300) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // watchdog for a hung handshake
    initial
    begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
